FILE: rtl/ddps_pkg.sv
// shared types, register indexes and reset values for the pd steering block
// no dependencies; used by ddps_csr, ddps_calc and the top level
package ddps_pkg;

   // field widths
   localparam int CENTER_W = 8;
   localparam int PWM_W    = 16;
   localparam int GAIN_W   = 16;
   localparam int LIMIT_W  = 15;
   localparam int ERR_W    = 9;
   localparam int DIFF_W   = 10;
   localparam int IDX_W    = 3;
   localparam int CSR_W    = 16;
   localparam int REQ_W    = 24;
   localparam int RSP_W    = 80;

   // register indexes
   localparam logic [IDX_W-1:0] REG_GAIN_P     = 3'd0;
   localparam logic [IDX_W-1:0] REG_GAIN_D     = 3'd1;
   localparam logic [IDX_W-1:0] REG_STEER_LIM  = 3'd2;
   localparam logic [IDX_W-1:0] REG_PWM_LOW    = 3'd3;
   localparam logic [IDX_W-1:0] REG_PWM_HIGH   = 3'd4;
   localparam logic [IDX_W-1:0] REG_DEADBAND   = 3'd5;
   localparam logic [IDX_W-1:0] REG_INVERT     = 3'd6;
   localparam logic [IDX_W-1:0] REG_MIDPOINT   = 3'd7;

   typedef struct packed {
      logic signed [GAIN_W-1:0]  gain_p;
      logic signed [GAIN_W-1:0]  gain_d;
      logic [LIMIT_W-1:0]        steer_limit;
      logic signed [PWM_W-1:0]   pwm_low;
      logic signed [PWM_W-1:0]   pwm_high;
      logic [CENTER_W-1:0]       deadband;
      logic                      invert;
      logic [CENTER_W-1:0]       midpoint;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      gain_p:      16'sd1024,
      gain_d:      16'sd384,
      steer_limit: 15'd8000,
      pwm_low:     -16'sd8000,
      pwm_high:    16'sd8000,
      deadband:    8'd0,
      invert:      1'b0,
      midpoint:    8'd128
   };

   // error history carried from one beat to the next
   typedef struct packed {
      logic signed [ERR_W-1:0] prev_error;
      logic                    valid;
   } hist_type;

   typedef struct packed {
      logic [CENTER_W-1:0]     center;
      logic signed [DIFF_W-1:0] diff;
      logic signed [ERR_W-1:0] err;
      logic signed [PWM_W-1:0] steer;
      logic signed [PWM_W-1:0] right;
      logic signed [PWM_W-1:0] left;
   } result_type;

endpackage

FILE: rtl/ddps_csr.sv
// configuration register file for the pd steering block
// depends on ddps_pkg
module ddps_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ddps_pkg::IDX_W-1:0]   csr_index,
   input  logic [ddps_pkg::CSR_W-1:0]   csr_data,
   output ddps_pkg::cfg_type            cfg
);

   ddps_pkg::cfg_type cfg_ff;
   ddps_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // decode one write beat
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ddps_pkg::REG_GAIN_P:    cfg_in.gain_p      = csr_data;
            ddps_pkg::REG_GAIN_D:    cfg_in.gain_d      = csr_data;
            ddps_pkg::REG_STEER_LIM: cfg_in.steer_limit = csr_data[ddps_pkg::LIMIT_W-1:0];
            ddps_pkg::REG_PWM_LOW:   cfg_in.pwm_low     = csr_data;
            ddps_pkg::REG_PWM_HIGH:  cfg_in.pwm_high    = csr_data;
            ddps_pkg::REG_DEADBAND:  cfg_in.deadband    = csr_data[ddps_pkg::CENTER_W-1:0];
            ddps_pkg::REG_INVERT:    cfg_in.invert      = csr_data[0];
            ddps_pkg::REG_MIDPOINT:  cfg_in.midpoint    = csr_data[ddps_pkg::CENTER_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ddps_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/ddps_calc.sv
// pd datapath: error, deadband, derivative, steering with q8.8 gains and wheel mix
// depends on ddps_pkg; purely combinational, sits between the pipeline registers
module ddps_calc (
   input  ddps_pkg::cfg_type                    cfg,
   input  ddps_pkg::hist_type                   hist,
   input  logic [ddps_pkg::CENTER_W-1:0]        center,
   input  logic signed [ddps_pkg::PWM_W-1:0]    base,
   output ddps_pkg::result_type                 res
);

   logic signed [8:0]  err_raw;
   logic signed [8:0]  err_inv;
   logic [8:0]         err_mag;
   logic signed [8:0]  err;
   logic signed [9:0]  diff;
   logic signed [24:0] prod_p;
   logic signed [25:0] prod_d;
   logic signed [26:0] acc;
   logic signed [18:0] acc_sh;
   logic signed [18:0] lim;
   logic signed [15:0] steer;
   logic signed [16:0] sum_left;
   logic signed [16:0] sum_right;

   // clamp a wheel sum; a value below low wins over one above high
   function automatic logic signed [15:0] wheel_sat(
      input logic signed [16:0] v,
      input logic signed [15:0] lo,
      input logic signed [15:0] hi
   );
      logic signed [15:0] r;
      priority if (v < 17'(lo)) begin
         r = lo;
      end else if (v > 17'(hi)) begin
         r = hi;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // error with inversion and deadband
   always_comb begin
      err_raw = $signed({1'b0, center}) - $signed({1'b0, cfg.midpoint});
      err_inv = cfg.invert ? -err_raw : err_raw;
      err_mag = err_inv[8] ? 9'(-err_inv) : 9'(err_inv);
      err     = (err_mag < {1'b0, cfg.deadband}) ? 9'sd0 : err_inv;
      diff    = hist.valid ? (10'(err) - 10'(hist.prev_error)) : 10'sd0;
   end

   // steering term, floor shift by 8, symmetric limit
   always_comb begin
      prod_p = 25'(cfg.gain_p) * 25'(err);
      prod_d = 26'(cfg.gain_d) * 26'(diff);
      acc    = 27'(prod_p) + 27'(prod_d);
      acc_sh = acc[26:8];
      lim    = $signed({4'b0000, cfg.steer_limit});
      priority if (acc_sh > lim) begin
         steer = lim[15:0];
      end else if (acc_sh < -lim) begin
         steer = 16'(-lim);
      end else begin
         steer = acc_sh[15:0];
      end
   end

   // wheel mix
   always_comb begin
      sum_left  = 17'(base) - 17'(steer);
      sum_right = 17'(base) + 17'(steer);
      res.left   = wheel_sat(sum_left, cfg.pwm_low, cfg.pwm_high);
      res.right  = wheel_sat(sum_right, cfg.pwm_low, cfg.pwm_high);
      res.steer  = steer;
      res.err    = err;
      res.diff   = diff;
      res.center = center;
   end

endmodule

FILE: rtl/differential_drive_pd_steering_unit.sv
// PD steering unit for a differential drive; top level with the pipeline registers
// depends on ddps_pkg, ddps_csr and ddps_calc
//
// Usage:
//   req channel: one beat per camera frame, carrying the track-center column
//   and the base wheel PWM. rsp channel: one beat per request with both wheel
//   PWMs, the steering value, the error and its change.
//   csr channel: register writes by index, always ready; write only while no
//   request is in flight.
//   Each request beat is taken into the input register and passes the datapath
//   into the result register. Throughput: one beat per cycle unless the receiver
//   stalls, set by the single pass of the datapath from input to result register.
//   Reset (synchronous, active high) loads the register defaults, empties both
//   pipeline registers and clears the error history, so the first result
//   after reset reports a zero error change.
//   When the receiver stalls, the result register holds its beat; at most one more
//   request is taken into the input register, after which req_tready drops
//   until rsp_tready returns.
module differential_drive_pd_steering_unit (
   input  logic                          clock,
   input  logic                          reset,
   // fields from bit 0 up: center_column[7:0], base_speed[15:0]
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [ddps_pkg::REQ_W-1:0]    req_tdata,
   // fields from bit 0 up: left wheel[15:0], right wheel[15:0], steer_value[15:0],
   // track_error[8:0], error_change[9:0], center_echo[7:0], zero fill[4:0]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ddps_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ddps_pkg::IDX_W-1:0]    csr_index,
   input  logic [ddps_pkg::CSR_W-1:0]    csr_data
);

   ddps_pkg::cfg_type    cfg;
   ddps_pkg::result_type res;

   logic                                 in_valid_ff;
   logic                                 in_valid_in;
   logic [ddps_pkg::CENTER_W-1:0]        center_ff;
   logic signed [ddps_pkg::PWM_W-1:0]    base_ff;
   logic                                 out_valid_ff;
   logic                                 out_valid_in;
   ddps_pkg::result_type                 rsp_ff;
   ddps_pkg::hist_type                   hist_ff;
   ddps_pkg::hist_type                   hist_in;
   logic                                 accept;
   logic                                 advance;

   ddps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ddps_calc u_calc (
      .cfg    (cfg),
      .hist   (hist_ff),
      .center (center_ff),
      .base   (base_ff),
      .res    (res)
   );

   // handshake and pipeline control
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign accept       = req_tvalid && req_tready;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   // history moves with each beat entering the result register
   always_comb begin
      hist_in = hist_ff;
      if (advance) begin
         hist_in.prev_error = res.err;
         hist_in.valid      = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         hist_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         hist_ff      <= hist_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         center_ff <= req_tdata[7:0];
         base_ff   <= req_tdata[23:8];
      end
      if (advance) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_ff};

   // first beat after reset reports no error change
   a_first_diff_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && !hist_ff.valid) |=> (rsp_ff.diff == '0))
      else $error("error change not zero on first beat");

   // steering stays within the configured limit
   a_steer_limit: assert property (@(posedge clock) disable iff (reset)
      advance |=> ((rsp_ff.steer <= $signed({1'b0, $past(cfg.steer_limit)}))
                && (rsp_ff.steer >= -$signed({1'b0, $past(cfg.steer_limit)}))))
      else $error("steering value beyond limit");

   // wheels stay within ordered bounds
   a_wheel_bounds: assert property (@(posedge clock) disable iff (reset)
      (advance && (cfg.pwm_low <= cfg.pwm_high)) |=>
         ((rsp_ff.left >= $past(cfg.pwm_low)) && (rsp_ff.left <= $past(cfg.pwm_high))
       && (rsp_ff.right >= $past(cfg.pwm_low)) && (rsp_ff.right <= $past(cfg.pwm_high))))
      else $error("wheel pwm outside bounds");

   // input side only stalls when both registers are full and the receiver waits
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("request stalled without a full pipeline");

   // history is recorded whenever a beat reaches the result register
   a_hist_track: assert property (@(posedge clock) disable iff (reset)
      advance |=> (hist_ff.valid && (hist_ff.prev_error == rsp_ff.err)))
      else $error("error history not updated");

endmodule

FILE: test/tb_differential_drive_pd_steering_unit.sv
`timescale 1ns / 100ps
// testbench for differential_drive_pd_steering_unit: directed and random camera frames
// with a scoreboard class that predicts each wheel mix; depends on ddps_pkg and the rtl
module tb_differential_drive_pd_steering_unit;
   import ddps_pkg::*;

   localparam int RANDOM_FRAMES = 1930;
   localparam int HOLD_CYCLES   = 80;
   localparam int CYCLE_LIMIT   = 600000;

   // predicts the wheel mix of every accepted frame and checks result beats in order
   class steering_scoreboard;
      cfg_type    cfg;
      logic signed [ERR_W-1:0] prev_err;
      bit         have_history;
      result_type expected_mix[$];
      int         fail_count;

      function new();
         cfg          = CFG_RESET;
         prev_err     = '0;
         have_history = 0;
         fail_count   = 0;
      endfunction

      function void write_reg(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         case (idx)
            REG_GAIN_P:    cfg.gain_p      = val;
            REG_GAIN_D:    cfg.gain_d      = val;
            REG_STEER_LIM: cfg.steer_limit = val[LIMIT_W-1:0];
            REG_PWM_LOW:   cfg.pwm_low     = val;
            REG_PWM_HIGH:  cfg.pwm_high    = val;
            REG_DEADBAND:  cfg.deadband    = val[CENTER_W-1:0];
            REG_INVERT:    cfg.invert      = val[0];
            REG_MIDPOINT:  cfg.midpoint    = val[CENTER_W-1:0];
            default: ;
         endcase
      endfunction

      // below low wins first, so crossed bounds give low for small values
      function int wheel_clamp(int v);
         int lo;
         int hi;
         lo = int'($signed(cfg.pwm_low));
         hi = int'($signed(cfg.pwm_high));
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      function void note_frame(logic [CENTER_W-1:0] center, logic signed [PWM_W-1:0] base);
         int         err;
         int         mag;
         int         change;
         int         lim;
         int         steer;
         longint     acc;
         result_type mix;
         err = int'(center) - int'(cfg.midpoint);
         if (cfg.invert) err = -err;
         mag = (err < 0) ? -err : err;
         if (mag < int'(cfg.deadband)) err = 0;
         change = have_history ? err - int'($signed(prev_err)) : 0;
         acc = longint'($signed(cfg.gain_p)) * longint'(err)
             + longint'($signed(cfg.gain_d)) * longint'(change);
         // arithmetic shift of a signed value rounds toward minus infinity
         acc = acc >>> 8;
         lim = int'(cfg.steer_limit);
         if (acc > lim) acc = lim;
         if (acc < -lim) acc = -lim;
         steer = int'(acc);
         mix.left   = PWM_W'(wheel_clamp(int'(base) - steer));
         mix.right  = PWM_W'(wheel_clamp(int'(base) + steer));
         mix.steer  = PWM_W'(steer);
         mix.err    = ERR_W'(err);
         mix.diff   = DIFF_W'(change);
         mix.center = center;
         prev_err     = ERR_W'(err);
         have_history = 1;
         expected_mix.push_back(mix);
      endfunction

      function void check_beat(logic [RSP_W-1:0] data);
         result_type got;
         result_type want;
         got = data[$bits(result_type)-1:0];
         if (expected_mix.size() == 0) begin
            $error("result beat with nothing expected: %h", data);
            fail_count++;
            return;
         end
         want = expected_mix.pop_front();
         if (got.left !== want.left) begin
            $error("left wheel expected %0d got %0d", want.left, got.left);
            fail_count++;
         end
         if (got.right !== want.right) begin
            $error("right wheel expected %0d got %0d", want.right, got.right);
            fail_count++;
         end
         if (got.steer !== want.steer) begin
            $error("steer_value expected %0d got %0d", want.steer, got.steer);
            fail_count++;
         end
         if (got.err !== want.err) begin
            $error("track_error expected %0d got %0d", want.err, got.err);
            fail_count++;
         end
         if (got.diff !== want.diff) begin
            $error("error_change expected %0d got %0d", want.diff, got.diff);
            fail_count++;
         end
         if (got.center !== want.center) begin
            $error("center_echo expected %0d got %0d", want.center, got.center);
            fail_count++;
         end
      endfunction

      function int pending();
         return expected_mix.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [IDX_W-1:0]     csr_index;
   logic [CSR_W-1:0]     csr_data;

   steering_scoreboard   sb;
   bit                   no_idle;
   bit                   hold_rsp;
   int                   cycles;

   differential_drive_pd_steering_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly no gap, sometimes a short one, rarely a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_differential_drive_pd_steering_unit failed");
         $finish;
      end
   end

   // monitor: results first, then register writes, then new frames
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_beat(rsp_tdata);
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready) sb.note_frame(req_tdata[7:0], req_tdata[23:8]);
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 0;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = no_idle ? 0 : pick_gap();
         end
      end
   end

   task automatic idle_req(int n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   // one frame beat, held until taken
   task automatic send_frame(logic [CENTER_W-1:0] center, logic signed [PWM_W-1:0] base);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) idle_req(gap);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {base, center};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop offering and let every expected result drain
   task automatic wait_drained();
      idle_req(1);
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_all(int gp, int gd, int lim, int lo, int hi, int db, int inv, int mid);
      write_reg(REG_GAIN_P, CSR_W'(gp));
      write_reg(REG_GAIN_D, CSR_W'(gd));
      write_reg(REG_STEER_LIM, CSR_W'(lim));
      write_reg(REG_PWM_LOW, CSR_W'(lo));
      write_reg(REG_PWM_HIGH, CSR_W'(hi));
      write_reg(REG_DEADBAND, CSR_W'(db));
      write_reg(REG_INVERT, CSR_W'(inv));
      write_reg(REG_MIDPOINT, CSR_W'(mid));
   endtask

   // random setting per register, extremes included; unused upper bits carry junk
   task automatic shuffle_config();
      logic [IDX_W-1:0] idx;
      logic [CSR_W-1:0] val;
      int               pick;
      for (int i = 0; i <= int'(REG_MIDPOINT); i++) begin
         idx  = IDX_W'(i);
         pick = $urandom_range(0, 5);
         if ($urandom_range(0, 3) != 0) begin
            case (idx)
               REG_GAIN_P, REG_GAIN_D:
                  val = (pick == 0) ? 16'h8000 : (pick == 1) ? 16'h7fff :
                        (pick < 4) ? CSR_W'($urandom_range(0, 4096) - 2048) : CSR_W'($urandom);
               REG_STEER_LIM:
                  val = {1'($urandom), (pick == 0) ? 15'd0 : (pick == 1) ? 15'h7fff :
                         15'($urandom_range(0, 12000))};
               REG_PWM_LOW:
                  val = (pick == 0) ? 16'h8000 : (pick == 1) ? CSR_W'($urandom) :
                        CSR_W'(-$urandom_range(0, 32768));
               REG_PWM_HIGH:
                  val = (pick == 0) ? 16'h7fff : (pick == 1) ? CSR_W'($urandom) :
                        CSR_W'($urandom_range(0, 32767));
               REG_DEADBAND:
                  val = {8'($urandom), (pick == 0) ? 8'd255 : (pick == 1) ? 8'($urandom) :
                         8'($urandom_range(0, 16))};
               default:
                  val = CSR_W'($urandom);
            endcase
            write_reg(idx, val);
         end
      end
   endtask

   task automatic random_frame();
      int c;
      int w;
      int r;
      logic signed [PWM_W-1:0] base;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         c = $urandom_range(0, 255);
      end else if (r < 88) begin
         // around the midpoint, crossing the deadband edges
         w = int'(sb.cfg.deadband) + 2;
         c = int'(sb.cfg.midpoint) + $urandom_range(0, 2 * w) - w;
         if (c < 0) c = 0;
         if (c > 255) c = 255;
      end else begin
         c = ($urandom_range(0, 1) != 0) ? 255 : 0;
      end
      r = $urandom_range(0, 9);
      if (r < 7) base = PWM_W'($urandom);
      else if (r < 9) base = PWM_W'($urandom_range(0, 4000) - 2000);
      else base = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      send_frame(CENTER_W'(c), base);
   endtask

   initial begin
      int sent;
      int phase;
      int phase_len;
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      no_idle    = 0;
      hold_rsp   = 0;
      cycles     = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults: first frame has no history, then the field extremes
      send_frame(8'd128, 16'sd0);
      send_frame(8'd255, 16'sh7fff);
      send_frame(8'd0, 16'sh8000);
      send_frame(8'd255, 16'sh8000);
      send_frame(8'd0, 16'sh7fff);
      send_frame(8'd130, 16'sd100);
      wait_drained();

      // largest gains and limits, inverted direction, midpoint at zero
      write_all(32767, -32768, 32767, -32768, 32767, 0, 1, 0);
      send_frame(8'd255, 16'sd0);
      send_frame(8'd0, 16'sh7fff);
      send_frame(8'd255, 16'sh8000);
      send_frame(8'd1, 16'sd1);
      wait_drained();

      // zero steer limit, crossed wheel bounds, widest deadband
      write_all(-32768, 32767, 0, 100, -100, 255, 0, 255);
      send_frame(8'd0, 16'sd0);
      send_frame(8'd254, 16'sd200);
      send_frame(8'd0, 16'sh8000);
      send_frame(8'd255, 16'sd50);
      wait_drained();

      // deadband edges with moderate gains and tight bounds
      write_all(256, 512, 500, -300, 300, 3, 0, 100);
      send_frame(8'd97, 16'sd0);
      send_frame(8'd98, 16'sd250);
      send_frame(8'd103, -16'sd250);
      send_frame(8'd102, 16'sd0);
      send_frame(8'd100, 16'sd10);
      wait_drained();

      // random phases, each under its own setting
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_FRAMES) begin
         if (phase > 0 && $urandom_range(0, 9) < 7) begin
            wait_drained();
            shuffle_config();
         end
         phase_len = $urandom_range(20, 150);
         if (phase_len > RANDOM_FRAMES - sent) phase_len = RANDOM_FRAMES - sent;
         no_idle = ($urandom_range(0, 3) == 0);
         // receiver holds off while frames keep coming, so the block backs up
         if (phase == 2) begin
            no_idle  = 1;
            hold_rsp = 1;
         end
         for (int k = 0; k < phase_len; k++) begin
            // sender pauses once until everything is back
            if (phase == 4 && k == phase_len / 2) wait_drained();
            random_frame();
         end
         sent += phase_len;
         phase++;
      end

      no_idle = 0;
      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0)
         $display("tb_differential_drive_pd_steering_unit passed");
      else
         $display("tb_differential_drive_pd_steering_unit failed");
      $finish;
   end

endmodule
